[rtl/lbp_pkg.sv]
package lbp_pkg;

   localparam int PATTERN_WIDTH  = 10;
   localparam int POSITION_WIDTH = 4;
   localparam int PATTERN_LENGTH = 10;
   localparam int NUM_PATTERNS   = 2;
   localparam int CSR_INDEX_WIDTH = 8;

   localparam logic [PATTERN_WIDTH-1:0] PATTERN_ZERO_RESET = 10'd5;
   localparam logic [PATTERN_WIDTH-1:0] PATTERN_ONE_RESET  = 10'd31;

   localparam logic [CSR_INDEX_WIDTH-1:0] REG_PATTERN_ZERO = 8'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_PATTERN_ONE  = 8'd1;

   localparam logic [2:0] CMD_TICK   = 3'd0;
   localparam logic [2:0] CMD_START  = 3'd1;
   localparam logic [2:0] CMD_PAUSE  = 3'd2;
   localparam logic [2:0] CMD_RESUME = 3'd3;
   localparam logic [2:0] CMD_STOP   = 3'd4;

   typedef struct packed {
      logic load;   // execute the accepted command and capture its result
   } lbp_cmd_type;

   // Bit of the selected pattern at a position; positions past the pattern read off.
   function automatic logic pattern_bit(
      input logic                      sel,
      input logic [POSITION_WIDTH-1:0] pos,
      input logic [PATTERN_WIDTH-1:0]  bits_zero,
      input logic [PATTERN_WIDTH-1:0]  bits_one
   );
      logic [PATTERN_WIDTH-1:0] bits;
      logic                     use_one;
      use_one = sel && (NUM_PATTERNS > 1);
      bits    = use_one ? bits_one : bits_zero;
      if ((int'(pos) >= PATTERN_LENGTH) || (int'(pos) >= PATTERN_WIDTH)) begin
         return 1'b0;
      end
      return bits[pos];
   endfunction

endpackage

[rtl/lbp_ctrl.sv]
module lbp_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output lbp_pkg::lbp_cmd_type cmd
);

   typedef enum logic {
      ST_EMPTY,
      ST_FULL
   } state_type;

   state_type state_ff;
   logic      rsp_valid_ff;
   logic      accept;

   // result register frees up in the same cycle it is taken
   assign req_stall = rsp_valid_ff & rsp_stall;
   assign accept    = req_valid & ~req_stall;
   assign rsp_valid = rsp_valid_ff;
   assign cmd.load  = accept;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_EMPTY;
         rsp_valid_ff <= 1'b0;
      end else begin
         unique case (state_ff)
            ST_EMPTY: begin
               if (accept) begin
                  state_ff     <= ST_FULL;
                  rsp_valid_ff <= 1'b1;
               end
            end
            ST_FULL: begin
               if (!rsp_stall && !req_valid) begin
                  state_ff     <= ST_EMPTY;
                  rsp_valid_ff <= 1'b0;
               end
            end
            default: begin
               state_ff     <= ST_EMPTY;
               rsp_valid_ff <= 1'b0;
            end
         endcase
      end
   end

endmodule

[rtl/lbp_datapath.sv]
module lbp_datapath #(
   parameter int NUM_SLOTS = 5
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  lbp_pkg::lbp_cmd_type                   cmd,
   input  logic [2:0]                             req_command,
   input  logic [7:0]                             req_slot_index,
   input  logic                                   req_start_pattern,
   input  logic [lbp_pkg::POSITION_WIDTH-1:0]     req_start_position,
   input  logic                                   req_start_enabled,
   input  logic                                   req_start_inverted,
   input  logic                                   req_start_claim,
   input  logic                                   csr_valid,
   output logic                                   csr_ready,
   input  logic [lbp_pkg::CSR_INDEX_WIDTH-1:0]    csr_index,
   input  logic [lbp_pkg::PATTERN_WIDTH-1:0]      csr_data,
   output logic [4:0]                             rsp_pin_levels,
   output logic [2:0]                             rsp_granted_slot
);

   localparam int PW = lbp_pkg::POSITION_WIDTH;

   logic [lbp_pkg::PATTERN_WIDTH-1:0] pattern_zero_ff;
   logic [lbp_pkg::PATTERN_WIDTH-1:0] pattern_one_ff;

   logic [NUM_SLOTS-1:0] in_use_ff,   in_use_in;
   logic [NUM_SLOTS-1:0] enabled_ff,  enabled_in;
   logic [NUM_SLOTS-1:0] inverted_ff, inverted_in;
   logic [NUM_SLOTS-1:0] pattern_ff,  pattern_in;
   logic [NUM_SLOTS-1:0] pin_ff,      pin_in;
   logic [PW-1:0]        position_ff [NUM_SLOTS];
   logic [PW-1:0]        position_in [NUM_SLOTS];

   logic [4:0]           pin_levels_ff;
   logic [2:0]           granted_ff, granted_in;
   logic [NUM_SLOTS+4:0] pin_pad;

   logic                 is_tick, is_start, is_pause, is_resume, is_stop, idx_ok;
   logic                 found;
   logic [PW:0]          pos_inc;

   assign csr_ready = 1'b1;

   assign is_tick   = (req_command == lbp_pkg::CMD_TICK);
   assign is_start  = (req_command == lbp_pkg::CMD_START);
   assign is_pause  = (req_command == lbp_pkg::CMD_PAUSE);
   assign is_resume = (req_command == lbp_pkg::CMD_RESUME);
   assign is_stop   = (req_command == lbp_pkg::CMD_STOP);
   assign idx_ok    = (int'(req_slot_index) < NUM_SLOTS);

   always_comb begin
      in_use_in   = in_use_ff;
      enabled_in  = enabled_ff;
      inverted_in = inverted_ff;
      pattern_in  = pattern_ff;
      pin_in      = pin_ff;
      granted_in  = 3'(NUM_SLOTS);
      found       = 1'b0;
      pos_inc     = '0;
      for (int k = 0; k < NUM_SLOTS; k++) begin
         position_in[k] = position_ff[k];
      end
      for (int k = 0; k < NUM_SLOTS; k++) begin
         if (is_tick) begin
            if (in_use_ff[k] && enabled_ff[k]) begin
               pin_in[k] = lbp_pkg::pattern_bit(pattern_ff[k], position_ff[k],
                                                pattern_zero_ff, pattern_one_ff)
                           ^ inverted_ff[k];
               pos_inc = {1'b0, position_ff[k]} + 1'b1;
               if (int'(pos_inc) >= lbp_pkg::PATTERN_LENGTH) begin
                  position_in[k] = '0;
               end else begin
                  position_in[k] = pos_inc[PW-1:0];
               end
            end
         end else if (is_start) begin
            // lowest free slot wins
            if (!in_use_ff[k] && !found) begin
               found          = 1'b1;
               pattern_in[k]  = req_start_pattern;
               position_in[k] = req_start_position;
               enabled_in[k]  = req_start_enabled;
               inverted_in[k] = req_start_inverted;
               in_use_in[k]   = req_start_claim;
               pin_in[k]      = req_start_inverted;
               granted_in     = 3'(k);
            end
         end else if (idx_ok && (int'(req_slot_index) == k)) begin
            if (is_pause) begin
               enabled_in[k] = 1'b0;
            end else if (is_resume) begin
               enabled_in[k] = 1'b1;
            end else if (is_stop) begin
               in_use_in[k] = 1'b0;
               pin_in[k]    = inverted_ff[k];
            end
         end
      end
   end

   assign pin_pad = {5'b0, pin_in};

   always_ff @(posedge clock) begin
      if (reset) begin
         pattern_zero_ff <= lbp_pkg::PATTERN_ZERO_RESET;
         pattern_one_ff  <= lbp_pkg::PATTERN_ONE_RESET;
      end else if (csr_valid && csr_ready) begin
         if (csr_index == lbp_pkg::REG_PATTERN_ZERO) begin
            pattern_zero_ff <= csr_data;
         end else if (csr_index == lbp_pkg::REG_PATTERN_ONE) begin
            pattern_one_ff <= csr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_use_ff   <= '0;
         enabled_ff  <= '0;
         inverted_ff <= '0;
         pattern_ff  <= '0;
         pin_ff      <= '0;
         for (int k = 0; k < NUM_SLOTS; k++) begin
            position_ff[k] <= '0;
         end
      end else if (cmd.load) begin
         in_use_ff   <= in_use_in;
         enabled_ff  <= enabled_in;
         inverted_ff <= inverted_in;
         pattern_ff  <= pattern_in;
         pin_ff      <= pin_in;
         for (int k = 0; k < NUM_SLOTS; k++) begin
            position_ff[k] <= position_in[k];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         pin_levels_ff <= pin_pad[4:0];
         granted_ff    <= granted_in;
      end
   end

   assign rsp_pin_levels   = pin_levels_ff;
   assign rsp_granted_slot = granted_ff;

endmodule

[rtl/led_blink_pattern_slots_top.sv]
// Channel | Direction | Handshake           | Payload
// req     | in        | req_valid/req_stall | command, slot_index, start_* fields
// rsp     | out       | rsp_valid/rsp_stall | pin_levels, granted_slot
// csr     | in        | csr_valid/csr_ready | csr_index, csr_data (pattern bits)
//
// Every command executes in the cycle of its transfer; its result is registered and
// shows on rsp in the next cycle. One command per cycle while rsp is not stalled.
// A stalled result holds the request side through req_stall; the result register is
// the only buffer. Synchronous reset clears all slots and the pins, and returns the
// patterns to their reset values.
module led_blink_pattern_slots_top #(
   parameter int NUM_SLOTS = 5
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic [2:0]                          req_command,
   input  logic [7:0]                          req_slot_index,
   input  logic                                req_start_pattern,
   input  logic [lbp_pkg::POSITION_WIDTH-1:0]  req_start_position,
   input  logic                                req_start_enabled,
   input  logic                                req_start_inverted,
   input  logic                                req_start_claim,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [4:0]                          rsp_pin_levels,
   output logic [2:0]                          rsp_granted_slot,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [lbp_pkg::CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [lbp_pkg::PATTERN_WIDTH-1:0]   csr_data
);

   lbp_pkg::lbp_cmd_type cmd;

   lbp_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .cmd       (cmd)
   );

   lbp_datapath #(
      .NUM_SLOTS (NUM_SLOTS)
   ) u_datapath (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .req_command        (req_command),
      .req_slot_index     (req_slot_index),
      .req_start_pattern  (req_start_pattern),
      .req_start_position (req_start_position),
      .req_start_enabled  (req_start_enabled),
      .req_start_inverted (req_start_inverted),
      .req_start_claim    (req_start_claim),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_index          (csr_index),
      .csr_data           (csr_data),
      .rsp_pin_levels     (rsp_pin_levels),
      .rsp_granted_slot   (rsp_granted_slot)
   );

endmodule

[tb/testbench.sv]
`timescale 1ns / 100ps

module testbench;

   localparam int POS_W   = lbp_pkg::POSITION_WIDTH;
   localparam int PAT_W   = lbp_pkg::PATTERN_WIDTH;
   localparam int IDX_W   = lbp_pkg::CSR_INDEX_WIDTH;
   localparam int PAT_LEN = lbp_pkg::PATTERN_LENGTH;

   localparam int SLOT_COUNT = 5;
   localparam logic [2:0] NO_SLOT = 3'(SLOT_COUNT);
   localparam logic [2:0] CMD_RSVD_5 = 3'd5;
   localparam logic [2:0] CMD_RSVD_6 = 3'd6;
   localparam logic [2:0] CMD_RSVD_7 = 3'd7;
   localparam int CYCLE_LIMIT = 200000;
   localparam int RANDOM_ITEMS = 400;

   typedef struct packed {
      logic [4:0] pins;
      logic [2:0] slot;
   } led_result_type;

   logic                                clock;
   logic                                reset;
   logic                                req_valid;
   logic                                req_stall;
   logic [2:0]                          req_command;
   logic [7:0]                          req_slot_index;
   logic                                req_start_pattern;
   logic [POS_W-1:0]                    req_start_position;
   logic                                req_start_enabled;
   logic                                req_start_inverted;
   logic                                req_start_claim;
   logic                                rsp_valid;
   logic                                rsp_stall;
   logic [4:0]                          rsp_pin_levels;
   logic [2:0]                          rsp_granted_slot;
   logic                                csr_valid;
   logic                                csr_ready;
   logic [IDX_W-1:0]                    csr_index;
   logic [PAT_W-1:0]                    csr_data;

   // shadow of the slot state
   logic             led_in_use   [SLOT_COUNT];
   logic             led_enabled  [SLOT_COUNT];
   logic             led_inverted [SLOT_COUNT];
   logic             led_pattern  [SLOT_COUNT];
   logic [POS_W-1:0] led_position [SLOT_COUNT];
   logic [4:0]       led_pins;
   logic [PAT_W-1:0] pat_zero_bits;
   logic [PAT_W-1:0] pat_one_bits;

   led_result_type expected_leds[$];
   led_result_type rsp_want;

   int send_gap_pct;
   int recv_stall_pct;
   int error_count;
   int cmds_sent;
   int ticks_sent;
   int grants_seen;
   int refusals_seen;
   int results_checked;
   int csr_writes;
   int cycle_count;

   led_blink_pattern_slots_top #(
      .NUM_SLOTS(SLOT_COUNT)
   ) i_dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_command        (req_command),
      .req_slot_index     (req_slot_index),
      .req_start_pattern  (req_start_pattern),
      .req_start_position (req_start_position),
      .req_start_enabled  (req_start_enabled),
      .req_start_inverted (req_start_inverted),
      .req_start_claim    (req_start_claim),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_pin_levels     (rsp_pin_levels),
      .rsp_granted_slot   (rsp_granted_slot),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_index          (csr_index),
      .csr_data           (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic logic blink_bit(input logic sel, input logic [POS_W-1:0] pos);
      logic [PAT_W-1:0] bits;
      bits = sel ? pat_one_bits : pat_zero_bits;
      if (int'(pos) >= PAT_LEN) return 1'b0;
      return bits[pos];
   endfunction

   function automatic void clear_slots();
      for (int k = 0; k < SLOT_COUNT; k++) begin
         led_in_use[k]   = 1'b0;
         led_enabled[k]  = 1'b0;
         led_inverted[k] = 1'b0;
         led_pattern[k]  = 1'b0;
         led_position[k] = '0;
      end
      led_pins      = '0;
      pat_zero_bits = lbp_pkg::PATTERN_ZERO_RESET;
      pat_one_bits  = lbp_pkg::PATTERN_ONE_RESET;
   endfunction

   // Apply one command to the shadow slots and return the pins and grant it yields.
   function automatic led_result_type apply_led_cmd(
      input logic [2:0]       cmd,
      input logic [7:0]       idx,
      input logic             pat,
      input logic [POS_W-1:0] pos,
      input logic             en,
      input logic             inv,
      input logic             claim
   );
      led_result_type res;
      logic           found;
      res.slot = NO_SLOT;
      found    = 1'b0;
      case (cmd)
         lbp_pkg::CMD_TICK: begin
            for (int k = 0; k < SLOT_COUNT; k++) begin
               if (led_in_use[k] && led_enabled[k]) begin
                  led_pins[k] = blink_bit(led_pattern[k], led_position[k]) ^ led_inverted[k];
                  if (int'(led_position[k]) + 1 >= PAT_LEN) led_position[k] = '0;
                  else led_position[k] = led_position[k] + 1'b1;
               end
            end
         end
         lbp_pkg::CMD_START: begin
            for (int k = 0; k < SLOT_COUNT; k++) begin
               if (!found && !led_in_use[k]) begin
                  found           = 1'b1;
                  led_pattern[k]  = pat;
                  led_position[k] = pos;
                  led_enabled[k]  = en;
                  led_inverted[k] = inv;
                  led_in_use[k]   = claim;
                  led_pins[k]     = inv;
                  res.slot        = 3'(k);
               end
            end
         end
         lbp_pkg::CMD_PAUSE: if (idx < SLOT_COUNT) led_enabled[idx] = 1'b0;
         lbp_pkg::CMD_RESUME: if (idx < SLOT_COUNT) led_enabled[idx] = 1'b1;
         lbp_pkg::CMD_STOP: begin
            if (idx < SLOT_COUNT) begin
               led_in_use[idx] = 1'b0;
               led_pins[idx]   = led_inverted[idx];
            end
         end
         default: ;
      endcase
      res.pins = led_pins;
      return res;
   endfunction

   task automatic send_led_cmd(
      input logic [2:0]       cmd,
      input logic [7:0]       idx,
      input logic             pat = 1'b0,
      input logic [POS_W-1:0] pos = '0,
      input logic             en = 1'b0,
      input logic             inv = 1'b0,
      input logic             claim = 1'b1
   );
      led_result_type res;
      while ($urandom_range(99) < send_gap_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid          <= 1'b1;
      req_command        <= cmd;
      req_slot_index     <= idx;
      req_start_pattern  <= pat;
      req_start_position <= pos;
      req_start_enabled  <= en;
      req_start_inverted <= inv;
      req_start_claim    <= claim;
      do @(posedge clock); while (req_stall);
      res = apply_led_cmd(cmd, idx, pat, pos, en, inv, claim);
      expected_leds.push_back(res);
      cmds_sent++;
      if (cmd == lbp_pkg::CMD_TICK) ticks_sent++;
      if (cmd == lbp_pkg::CMD_START) begin
         if (res.slot == NO_SLOT) refusals_seen++;
         else grants_seen++;
      end
   endtask

   // Hold the sender until every result is back; the block is then idle.
   task automatic wait_until_idle();
      req_valid <= 1'b0;
      while (expected_leds.size() != 0) @(posedge clock);
      repeat (2) @(posedge clock);
   endtask

   task automatic write_pattern(input logic [IDX_W-1:0] idx,
                                input logic [PAT_W-1:0] bits);
      wait_until_idle();
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= bits;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      if (idx == lbp_pkg::REG_PATTERN_ZERO) pat_zero_bits = bits;
      else if (idx == lbp_pkg::REG_PATTERN_ONE) pat_one_bits = bits;
      csr_writes++;
   endtask

   task automatic test_start_grants();
      send_led_cmd(lbp_pkg::CMD_START, 8'd0, 1'b0, 4'd0, 1'b1, 1'b0, 1'b1);
      send_led_cmd(lbp_pkg::CMD_START, 8'd0, 1'b1, 4'd9, 1'b1, 1'b1, 1'b1);
      // unclaimed start: slot loaded but left free
      send_led_cmd(lbp_pkg::CMD_START, 8'd255, 1'b1, 4'd15, 1'b0, 1'b1, 1'b0);
      send_led_cmd(lbp_pkg::CMD_START, 8'd0, 1'b0, 4'd12, 1'b1, 1'b0, 1'b1);
      send_led_cmd(lbp_pkg::CMD_START, 8'd0, 1'b1, 4'd3, 1'b0, 1'b0, 1'b1);
      send_led_cmd(lbp_pkg::CMD_START, 8'd0, 1'b0, 4'd0, 1'b1, 1'b1, 1'b1);
      send_led_cmd(lbp_pkg::CMD_START, 8'd0, 1'b1, 4'd5, 1'b1, 1'b1, 1'b1);
   endtask

   task automatic test_tick_patterns();
      repeat (3) send_led_cmd(lbp_pkg::CMD_TICK, 8'd0);
   endtask

   task automatic test_slot_control();
      send_led_cmd(lbp_pkg::CMD_PAUSE, 8'd0);
      send_led_cmd(lbp_pkg::CMD_RESUME, 8'd3);
      send_led_cmd(lbp_pkg::CMD_PAUSE, 8'(SLOT_COUNT));
      send_led_cmd(lbp_pkg::CMD_STOP, 8'd255);
      send_led_cmd(lbp_pkg::CMD_STOP, 8'd1);
      send_led_cmd(lbp_pkg::CMD_STOP, 8'd1);
      send_led_cmd(lbp_pkg::CMD_RESUME, 8'd1);
      send_led_cmd(lbp_pkg::CMD_PAUSE, 8'd1);
      send_led_cmd(CMD_RSVD_5, 8'd0, 1'b1, 4'd1, 1'b1, 1'b1, 1'b1);
      send_led_cmd(CMD_RSVD_6, 8'd2);
      send_led_cmd(CMD_RSVD_7, 8'd128);
      send_led_cmd(lbp_pkg::CMD_TICK, 8'd0);
   endtask

   task automatic test_pattern_registers();
      write_pattern(lbp_pkg::REG_PATTERN_ZERO, '1);
      write_pattern(lbp_pkg::REG_PATTERN_ONE, '0);
      repeat (2) send_led_cmd(lbp_pkg::CMD_TICK, 8'd0);
      write_pattern(lbp_pkg::REG_PATTERN_ZERO, '0);
      write_pattern(lbp_pkg::REG_PATTERN_ONE, '1);
      repeat (2) send_led_cmd(lbp_pkg::CMD_TICK, 8'd0);
   endtask

   // Mostly sensible slot traffic, with stray indexes, odd positions and unknown commands.
   task automatic test_random_traffic(input int count, input bit hold_midway);
      int               pick;
      logic [2:0]       cmd;
      logic [7:0]       idx;
      logic [POS_W-1:0] pos;
      write_pattern(lbp_pkg::REG_PATTERN_ZERO, PAT_W'($urandom));
      write_pattern(lbp_pkg::REG_PATTERN_ONE, PAT_W'($urandom));
      for (int n = 0; n < count; n++) begin
         pick = $urandom_range(99);
         if (pick < 40) cmd = lbp_pkg::CMD_TICK;
         else if (pick < 62) cmd = lbp_pkg::CMD_START;
         else if (pick < 71) cmd = lbp_pkg::CMD_PAUSE;
         else if (pick < 81) cmd = lbp_pkg::CMD_RESUME;
         else if (pick < 95) cmd = lbp_pkg::CMD_STOP;
         else cmd = 3'($urandom_range(CMD_RSVD_5, CMD_RSVD_7));
         idx = ($urandom_range(99) < 85) ? 8'($urandom_range(SLOT_COUNT - 1))
                                         : 8'($urandom);
         pos = ($urandom_range(99) < 85) ? POS_W'($urandom_range(PAT_LEN - 1))
                                         : POS_W'($urandom);
         send_led_cmd(cmd, idx, 1'($urandom), pos, 1'($urandom), 1'($urandom),
                      $urandom_range(99) < 90);
         if (hold_midway && n == count / 2) wait_until_idle();
      end
   endtask

   always @(posedge clock) begin
      rsp_stall <= ($urandom_range(99) < recv_stall_pct);
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_leds.size() == 0) begin
            $display("%0t: result with nothing pending: pins=%b slot=%0d",
                     $time, rsp_pin_levels, rsp_granted_slot);
            error_count++;
         end else begin
            rsp_want = expected_leds.pop_front();
            if (rsp_pin_levels !== rsp_want.pins) begin
               $display("%0t: pin_levels expected %b actual %b",
                        $time, rsp_want.pins, rsp_pin_levels);
               error_count++;
            end
            if (rsp_granted_slot !== rsp_want.slot) begin
               $display("%0t: granted_slot expected %0d actual %0d",
                        $time, rsp_want.slot, rsp_granted_slot);
               error_count++;
            end
            results_checked++;
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("%0t: timeout, %0d results pending", $time, expected_leds.size());
         $display("[led_blink_pattern_slots_top] ERROR");
         $finish;
      end
   end

   initial begin
      reset              <= 1'b1;
      req_valid          <= 1'b0;
      req_command        <= lbp_pkg::CMD_TICK;
      req_slot_index     <= '0;
      req_start_pattern  <= 1'b0;
      req_start_position <= '0;
      req_start_enabled  <= 1'b0;
      req_start_inverted <= 1'b0;
      req_start_claim    <= 1'b0;
      rsp_stall          <= 1'b0;
      csr_valid          <= 1'b0;
      csr_index          <= '0;
      csr_data           <= '0;
      send_gap_pct   = 16;
      recv_stall_pct = 47;
      clear_slots();
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_start_grants();
      test_tick_patterns();
      test_slot_control();
      test_pattern_registers();

      test_random_traffic(RANDOM_ITEMS, 1'b1);
      send_gap_pct   = 47;
      recv_stall_pct = 16;
      test_random_traffic(RANDOM_ITEMS, 1'b0);
      send_gap_pct   = 0;
      recv_stall_pct = 0;
      test_random_traffic(RANDOM_ITEMS, 1'b0);

      wait_until_idle();
      repeat (4) @(posedge clock);
      $display("Sent %0d commands: %0d ticks, %0d starts granted, %0d starts refused.",
               cmds_sent, ticks_sent, grants_seen, refusals_seen);
      $display("Checked %0d results across %0d pattern register writes.",
               results_checked, csr_writes);
      if (error_count == 0) begin
         $display("[led_blink_pattern_slots_top] OK");
      end else begin
         $display("[led_blink_pattern_slots_top] ERROR");
      end
      $finish;
   end

endmodule
